@@ rtl/core/lssr_pkg.sv @@
// lssr_pkg: shared constants, item kind codes, intensity remap and the
// command/status structs between controller and datapath
// no dependencies
package lssr_pkg;

	localparam int LEDS_PER_STRIP_DEF = 33;
	localparam int STRIPS_DEF         = 2;

	localparam logic [15:0] REFRESH_RESET = 16'd250;
	localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
	localparam logic [7:0]  PEND_RESET    = 8'hFF;
	localparam logic [7:0]  SENT_RESET    = 8'h00;
	localparam logic [7:0]  SLOT_MASK     = 8'h03;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_POLL = 2'd2;

	localparam logic REG_REFRESH = 1'b0;

	typedef struct packed {
		logic take_id;
		logic take_lvl;
		logic tick;
		logic poll;
		logic store_rd;
		logic store_wr;
		logic stream_rd;
		logic stream_ld;
		logic stream_next;
	} lssr_cmd_t;

	typedef struct packed {
		logic expect_id;
		logic id_ok;
		logic send;
		logic last;
		logic out_taken;
	} lssr_sts_t;

	function automatic logic [1:0] weight_map(input logic [1:0] lvl);
		logic [1:0] w;
		case (lvl)
			2'd0: w = 2'd0;
			2'd1: w = 2'd2;
			2'd2: w = 2'd1;
			default: w = 2'd3;
		endcase
		return w;
	endfunction

endpackage

@@ rtl/core/lssr_ctrl.sv @@
// lssr_ctrl: controller state machine, sequences id/intensity stores,
// ticks, polls and the frame stream; depends on lssr_pkg
module lssr_ctrl import lssr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  lssr_sts_t  sts,
	output lssr_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ST_RD = 3'd1;
	localparam logic [2:0] S_ST_WR = 3'd2;
	localparam logic [2:0] S_SR_RD = 3'd3;
	localparam logic [2:0] S_SR_LD = 3'd4;
	localparam logic [2:0] S_SR_HD = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid & in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (kind)
						KIND_BYTE: begin
							if (sts.expect_id) begin
								cmd.take_id = 1'b1;
							end else begin
								cmd.take_lvl = 1'b1;
								if (sts.id_ok) state_d = S_ST_RD;
							end
						end
						KIND_TICK: cmd.tick = 1'b1;
						KIND_POLL: begin
							cmd.poll = 1'b1;
							if (sts.send) state_d = S_SR_RD;
						end
						default: ;
					endcase
				end
			end
			S_ST_RD: begin
				cmd.store_rd = 1'b1;
				state_d      = S_ST_WR;
			end
			S_ST_WR: begin
				cmd.store_wr = 1'b1;
				state_d      = S_IDLE;
			end
			S_SR_RD: begin
				cmd.stream_rd = 1'b1;
				state_d       = S_SR_LD;
			end
			S_SR_LD: begin
				cmd.stream_ld = 1'b1;
				state_d       = S_SR_HD;
			end
			S_SR_HD: begin
				if (sts.out_taken) begin
					if (sts.last) begin
						state_d = S_IDLE;
					end else begin
						cmd.stream_next = 1'b1;
						state_d         = S_SR_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/lssr_dp.sv @@
// lssr_dp: datapath with pending and sent shadow memories, pairing state,
// millisecond counter, interval register and output register; depends on lssr_pkg
module lssr_dp import lssr_pkg::*; #(
	parameter int LEDS_PER_STRIP = LEDS_PER_STRIP_DEF,
	parameter int STRIPS         = STRIPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  lssr_cmd_t   cmd,
	output lssr_sts_t   sts,
	input  logic [7:0]  data_byte,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic [15:0] interval,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tx_byte,
	output logic        last_byte
);

	localparam int SB = (LEDS_PER_STRIP * 2 * STRIPS + 7) / 8;
	localparam int AW = (SB > 1) ? $clog2(SB) : 1;

	logic [7:0]    pend_mem [SB];
	logic [7:0]    sent_mem [SB];
	logic [SB-1:0] pend_vld_q;
	logic          sent_init_q;
	logic [7:0]    pend_rd_q;
	logic          pend_rv_q;
	logic [7:0]    sent_rd_q;

	logic          dirty_q;
	logic          expect_id_q;
	logic [7:0]    held_id_q;
	logic [15:0]   ms_q;
	logic [15:0]   interval_q;
	logic [1:0]    lvl_q;
	logic          copy_q;
	logic [AW-1:0] idx_q;
	logic [7:0]    tx_byte_q;
	logic          last_q;
	logic          out_valid_q;

	logic [6:0]    pos_w;
	logic [AW-1:0] pos;
	logic [AW-1:0] rd_addr;
	logic [2:0]    sh;
	logic [7:0]    pend_data;
	logic [7:0]    sent_data;
	logic [7:0]    new_byte;
	logic          idx_last;
	logic          send;

	assign pos_w     = 7'(SB - 1) - {1'b0, held_id_q[7:2]};
	assign pos       = pos_w[AW-1:0];
	assign rd_addr   = cmd.store_rd ? pos : idx_q;
	assign sh        = {held_id_q[1:0], 1'b0};
	assign pend_data = pend_rv_q ? pend_rd_q : PEND_RESET;
	assign sent_data = sent_init_q ? sent_rd_q : SENT_RESET;
	assign new_byte  = (pend_data & ~(SLOT_MASK << sh)) | ({6'b0, lvl_q} << sh);
	assign idx_last  = (idx_q == AW'(SB - 1));
	assign send      = dirty_q | (ms_q >= interval_q);

	assign sts.expect_id = expect_id_q;
	assign sts.id_ok     = ({1'b0, held_id_q[7:2]} < 7'(SB));
	assign sts.send      = send;
	assign sts.last      = idx_last;
	assign sts.out_taken = out_valid_q & out_ready;

	assign interval  = interval_q;
	assign out_valid = out_valid_q;
	assign tx_byte   = tx_byte_q;
	assign last_byte = last_q;

	// shadow memories, intensity level and output byte registers
	always_ff @(posedge clk) begin
		if (cmd.store_rd | cmd.stream_rd) begin
			pend_rd_q <= pend_mem[rd_addr];
			pend_rv_q <= pend_vld_q[rd_addr];
			sent_rd_q <= sent_mem[rd_addr];
		end
		if (cmd.store_wr) begin
			pend_mem[pos] <= new_byte;
		end
		if (cmd.stream_ld & copy_q) begin
			sent_mem[idx_q] <= pend_data;
		end
		if (cmd.take_lvl) begin
			lvl_q <= weight_map(data_byte[1:0]);
		end
		if (cmd.stream_ld) begin
			tx_byte_q <= copy_q ? pend_data : sent_data;
			last_q    <= idx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q  <= '0;
			sent_init_q <= 1'b0;
			dirty_q     <= 1'b1;
			expect_id_q <= 1'b1;
			held_id_q   <= 8'd0;
			ms_q        <= 16'd0;
			interval_q  <= REFRESH_RESET;
			copy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) interval_q <= cfg_wdata;
			if (cmd.take_id) begin
				held_id_q   <= data_byte;
				expect_id_q <= 1'b0;
			end
			if (cmd.take_lvl) expect_id_q <= 1'b1;
			if (cmd.store_wr) begin
				pend_vld_q[pos] <= 1'b1;
				if (new_byte != sent_data) dirty_q <= 1'b1;
			end
			if (cmd.tick && ms_q != COUNT_MAX) ms_q <= ms_q + 16'd1;
			if (cmd.poll) begin
				dirty_q <= 1'b0;
				if (send) begin
					ms_q   <= 16'd0;
					copy_q <= dirty_q;
					idx_q  <= '0;
				end
			end
			if (cmd.stream_ld) begin
				out_valid_q <= 1'b1;
				if (copy_q && idx_last) sent_init_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.stream_next) idx_q <= idx_q + AW'(1);
		end
	end

endmodule

@@ rtl/core/led_strip_shadow_refresh.sv @@
// led_strip_shadow_refresh: top level, APB register decode and the
// controller/datapath pair; depends on lssr_pkg, lssr_ctrl, lssr_dp
// handling: an id byte, a tick, a quiet poll or an intensity byte for an id outside the
// shadow stays in idle; any other intensity byte passes shadow read, then write back
// a sending poll streams the frame byte by byte: read the entry, load the output register,
// then hold until out_ready takes it; the next byte is read only after the last is taken
// reset: asynchronous, clears control state; shadows read as reset values through valid bits and an init flag
module led_strip_shadow_refresh import lssr_pkg::*; #(
	parameter int LEDS_PER_STRIP = LEDS_PER_STRIP_DEF,
	parameter int STRIPS         = STRIPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tx_byte,
	output logic        last_byte,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	lssr_cmd_t   cmd;
	lssr_sts_t   sts;
	logic        cfg_we;
	logic [15:0] interval;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_REFRESH);
	assign prdata = (paddr[2] == REG_REFRESH) ? {16'd0, interval} : 32'd0;

	lssr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	lssr_dp #(
		.LEDS_PER_STRIP (LEDS_PER_STRIP),
		.STRIPS         (STRIPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.data_byte (data_byte),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata[15:0]),
		.interval  (interval),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tx_byte   (tx_byte),
		.last_byte (last_byte)
	);

endmodule

@@ rtl/core/lssr_chk.sv @@
// lssr_chk: port-level checks on the frame stream and input handshake,
// bound to the top level; depends on lssr_pkg
module lssr_chk import lssr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] kind,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] tx_byte,
	input logic       last_byte
);

	// no item taken while a frame is streaming
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken during frame stream");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(last_byte))
		else $error("stalled output item changed");

	// frame bytes come out with a gap while the next entry is read
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("output item without read gap");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_byte |=> in_ready)
		else $error("not ready after frame end");

	a_tick_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_TICK |=> in_ready)
		else $error("tick item took more than one cycle");

endmodule

bind led_strip_shadow_refresh lssr_chk u_lssr_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.kind      (kind),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.tx_byte   (tx_byte),
	.last_byte (last_byte)
);
